>>> src/sha1md_pkg.sv
// Shared types and constants for the SHA-1 message digest block.
// No dependencies; imported by sha1_message_digest and sha1md_checker.
package sha1md_pkg;

   localparam logic OP_ABSORB = 1'b0;
   localparam logic OP_FINISH = 1'b1;

   localparam int WORD_COUNT = 5;
   localparam logic [2:0] LAST_INDEX = 3'd4;

   localparam logic [7:0] PAD_BYTE = 8'h80;
   localparam logic [5:0] LEN_POS  = 6'd56;
   localparam logic [5:0] LAST_POS = 6'd63;
   localparam logic [6:0] LAST_ROUND = 7'd79;

   localparam logic [31:0] IV [WORD_COUNT] = '{
      32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
   };

   localparam logic [31:0] K_ROUND [4] = '{
      32'h5A827999, 32'h6ED9EBA1, 32'h8F1BBCDC, 32'hCA62C1D6
   };

   typedef struct packed {
      logic       operation;
      logic [7:0] data_byte;
   } req_type;

   typedef struct packed {
      logic [31:0] digest_word;
      logic [2:0]  word_index;
      logic        last_word;
   } rsp_type;

endpackage

>>> src/sha1_message_digest.sv
// SHA-1 message digest over a byte stream, one round per cycle.
// Depends on sha1md_pkg (types, initial vector, round constants).
//
//  channel | dir | handshake           | payload
//  --------+-----+---------------------+---------------------------------------
//  req     | in  | req_valid/req_ready | operation, data_byte (absorb / finish)
//  rsp     | out | rsp_valid/rsp_ready | digest_word, word_index, last_word
//
// An absorb transaction shifts its byte into the message window; the 64th byte
// of a block starts 80 rounds on the single round unit, then the chaining adds.
// A finish transaction feeds 9 to 72 pad bytes at one per cycle outside compression,
// runs one or two compressions, then offers five result transactions, one per cycle while rsp_ready is high.
// req_ready is high only while idle. Synchronous active-high reset loads the
// initial vector and clears position, length and control state.
module sha1_message_digest
   import sha1md_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PAD,
      ST_COMPRESS,
      ST_ADD,
      ST_EMIT
   } state_type;

   state_type state_ff, state_in;

   // Message window: bytes shift in at the low end, so word 0 sits at the top.
   // During compression the same register is the 16-word schedule window.
   logic [511:0] msg_ff, msg_in;
   logic [31:0]  h_ff [WORD_COUNT];
   logic [31:0]  h_in [WORD_COUNT];
   logic [31:0]  a_ff, b_ff, c_ff, d_ff, e_ff;
   logic [31:0]  a_in, b_in, c_in, d_in, e_in;
   logic [5:0]   pos_ff, pos_in;
   logic [60:0]  total_ff, total_in;
   logic [63:0]  len_ff, len_in;
   logic [6:0]   round_ff, round_in;
   logic [2:0]   idx_ff, idx_in;
   logic         first_ff, first_in;         // next pad byte is the 0x80 marker
   logic         len_active_ff, len_active_in; // length bytes under way
   logic         pad_mode_ff, pad_mode_in;   // a finish is in progress
   logic         final_ff, final_in;         // current compression is the last

   logic         req_fire;
   logic         pad_sel_len;
   logic [7:0]   pad_byte;
   logic [31:0]  w0, w2, w8, w13, w_new;
   logic [31:0]  f_val, k_val, t_val;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign rsp_valid = (state_ff == ST_EMIT);

   assign rsp_data.digest_word = h_ff[idx_ff];
   assign rsp_data.word_index  = idx_ff;
   assign rsp_data.last_word   = (idx_ff == LAST_INDEX);

   // Padding byte source: marker, zeros up to offset 56, then the bit length.
   assign pad_sel_len = !first_ff && ((pos_ff == LEN_POS) || len_active_ff);
   assign pad_byte    = first_ff ? PAD_BYTE : (pad_sel_len ? len_ff[63:56] : 8'h00);

   // Schedule taps: w[t], w[t+2], w[t+8], w[t+13] of the sliding window.
   assign w0    = msg_ff[511:480];
   assign w2    = msg_ff[447:416];
   assign w8    = msg_ff[255:224];
   assign w13   = msg_ff[95:64];
   assign w_new = {(w13[30:0] ^ w8[30:0] ^ w2[30:0] ^ w0[30:0]),
                   (w13[31] ^ w8[31] ^ w2[31] ^ w0[31])};

   // Round function and constant by round group.
   always_comb begin
      if (round_ff < 7'd20) begin
         f_val = (b_ff & c_ff) | (~b_ff & d_ff);
         k_val = K_ROUND[0];
      end else if (round_ff < 7'd40) begin
         f_val = b_ff ^ c_ff ^ d_ff;
         k_val = K_ROUND[1];
      end else if (round_ff < 7'd60) begin
         f_val = (b_ff & c_ff) | (b_ff & d_ff) | (c_ff & d_ff);
         k_val = K_ROUND[2];
      end else begin
         f_val = b_ff ^ c_ff ^ d_ff;
         k_val = K_ROUND[3];
      end
   end

   assign t_val = {a_ff[26:0], a_ff[31:27]} + f_val + e_ff + k_val + w0;

   always_comb begin
      state_in      = state_ff;
      msg_in        = msg_ff;
      a_in          = a_ff;
      b_in          = b_ff;
      c_in          = c_ff;
      d_in          = d_ff;
      e_in          = e_ff;
      pos_in        = pos_ff;
      total_in      = total_ff;
      len_in        = len_ff;
      round_in      = round_ff;
      idx_in        = idx_ff;
      first_in      = first_ff;
      len_active_in = len_active_ff;
      pad_mode_in   = pad_mode_ff;
      final_in      = final_ff;
      for (int i = 0; i < WORD_COUNT; i++) begin
         h_in[i] = h_ff[i];
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_data.operation == OP_ABSORB) begin
                  msg_in   = {msg_ff[503:0], req_data.data_byte};
                  pos_in   = pos_ff + 6'd1;
                  total_in = total_ff + 61'd1;
                  if (pos_ff == LAST_POS) begin
                     state_in = ST_COMPRESS;
                     round_in = '0;
                     a_in     = h_ff[0];
                     b_in     = h_ff[1];
                     c_in     = h_ff[2];
                     d_in     = h_ff[3];
                     e_in     = h_ff[4];
                  end
               end else begin
                  state_in      = ST_PAD;
                  len_in        = {total_ff, 3'b000};
                  first_in      = 1'b1;
                  len_active_in = 1'b0;
                  pad_mode_in   = 1'b1;
               end
            end
         end

         ST_PAD: begin
            msg_in   = {msg_ff[503:0], pad_byte};
            pos_in   = pos_ff + 6'd1;
            first_in = 1'b0;
            if (pad_sel_len) begin
               len_active_in = 1'b1;
               len_in        = {len_ff[55:0], 8'h00};
            end
            if (pos_ff == LAST_POS) begin
               state_in = ST_COMPRESS;
               final_in = pad_sel_len;
               round_in = '0;
               a_in     = h_ff[0];
               b_in     = h_ff[1];
               c_in     = h_ff[2];
               d_in     = h_ff[3];
               e_in     = h_ff[4];
            end
         end

         ST_COMPRESS: begin
            a_in     = t_val;
            b_in     = a_ff;
            c_in     = {b_ff[1:0], b_ff[31:2]};
            d_in     = c_ff;
            e_in     = d_ff;
            msg_in   = {msg_ff[479:0], w_new};
            round_in = round_ff + 7'd1;
            if (round_ff == LAST_ROUND) begin
               state_in = ST_ADD;
            end
         end

         ST_ADD: begin
            h_in[0] = h_ff[0] + a_ff;
            h_in[1] = h_ff[1] + b_ff;
            h_in[2] = h_ff[2] + c_ff;
            h_in[3] = h_ff[3] + d_ff;
            h_in[4] = h_ff[4] + e_ff;
            if (final_ff) begin
               state_in = ST_EMIT;
               idx_in   = '0;
            end else if (pad_mode_ff) begin
               state_in = ST_PAD;
            end else begin
               state_in = ST_IDLE;
            end
         end

         ST_EMIT: begin
            if (rsp_ready) begin
               if (idx_ff == LAST_INDEX) begin
                  state_in      = ST_IDLE;
                  pos_in        = '0;
                  total_in      = '0;
                  pad_mode_in   = 1'b0;
                  final_in      = 1'b0;
                  len_active_in = 1'b0;
                  for (int i = 0; i < WORD_COUNT; i++) begin
                     h_in[i] = IV[i];
                  end
               end else begin
                  idx_in = idx_ff + 3'd1;
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      msg_ff   <= msg_in;
      a_ff     <= a_in;
      b_ff     <= b_in;
      c_ff     <= c_in;
      d_ff     <= d_in;
      e_ff     <= e_in;
      len_ff   <= len_in;
      round_ff <= round_in;
      if (reset) begin
         state_ff      <= ST_IDLE;
         pos_ff        <= '0;
         total_ff      <= '0;
         idx_ff        <= '0;
         first_ff      <= 1'b0;
         len_active_ff <= 1'b0;
         pad_mode_ff   <= 1'b0;
         final_ff      <= 1'b0;
         for (int i = 0; i < WORD_COUNT; i++) begin
            h_ff[i] <= IV[i];
         end
      end else begin
         state_ff      <= state_in;
         pos_ff        <= pos_in;
         total_ff      <= total_in;
         idx_ff        <= idx_in;
         first_ff      <= first_in;
         len_active_ff <= len_active_in;
         pad_mode_ff   <= pad_mode_in;
         final_ff      <= final_in;
         for (int i = 0; i < WORD_COUNT; i++) begin
            h_ff[i] <= h_in[i];
         end
      end
   end

endmodule

>>> src/sha1md_checker.sv
// Port-level checks for sha1_message_digest, attached by bind.
// Depends on sha1md_pkg and the top level's port list.
module sha1md_port_checks
   import sha1md_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input req_type req_data,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   // A stalled result transaction holds its payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("rsp payload changed while stalled");

   // No new request is taken while digest words are being offered.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("req_ready high during digest output");

   // Last-word mark goes with index 4, and the index never passes 4.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.last_word == (rsp_data.word_index == LAST_INDEX)) &&
                    (rsp_data.word_index <= LAST_INDEX))
      else $error("bad word index or last-word mark");

   // Digest words follow one another without gaps.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_data.last_word |=>
         rsp_valid && (rsp_data.word_index == $past(rsp_data.word_index) + 3'd1))
      else $error("digest word sequence broken");

   // Padding keeps the block busy the cycle after a finish.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_data.operation == OP_FINISH) |=>
         !req_ready && !rsp_valid)
      else $error("block not busy after finish");

endmodule

bind sha1_message_digest sha1md_port_checks u_sha1md_port_checks (.*);
